// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the address decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/cbad_pkg.sv =====
// types, codes and constants of the cpu bus address decoder
`timescale 1ns / 1ps

package cbad_pkg;

    // default target sizes in bytes, all powers of two
    localparam int ITCM_PHYS_BYTES_DEF = 32768;
    localparam int DTCM_PHYS_BYTES_DEF = 16384;
    localparam int BIOS_BYTES_DEF      = 65536;
    localparam int WORKRAM_BYTES_DEF   = 1048576;
    localparam int SHAREDRAM_BYTES_DEF = 32768;
    localparam int FCRAM_BYTES_DEF     = 134217728;

    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 27;
    localparam int CFG_IDX_W = 3;

    // memory map
    localparam logic [31:0] BIOS_BASE      = 32'hFFFF_0000;
    localparam logic [31:0] REGION_MASK_128M = 32'hF800_0000;
    localparam logic [31:0] WORKRAM_BASE   = 32'h0800_0000;
    localparam logic [31:0] IO_BASE        = 32'h1000_0000;
    localparam logic [31:0] IO_END         = 32'h1020_0000;
    localparam logic [31:0] VRAM_BASE      = 32'h1800_0000;
    localparam logic [31:0] VRAM_B_BASE    = 32'h1830_0000;
    localparam logic [31:0] VRAM_END       = 32'h1860_0000;
    localparam logic [31:0] REGION_MASK_512K = 32'hFFF8_0000;
    localparam logic [31:0] SHAREDRAM_BASE = 32'h1FF0_0000;
    localparam logic [31:0] AXIRAM_BASE    = 32'h1FF8_0000;
    localparam logic [31:0] FCRAM0_BASE    = 32'h2000_0000;
    localparam logic [31:0] FCRAM1_BASE    = 32'h2800_0000;
    localparam logic [OFFSET_W-1:0] AXIRAM_OFF_MASK = 27'h007_FFFF;

    // access mode codes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_STORE = 2'd1;
    localparam logic [1:0] MODE_FETCH = 2'd2;

    // access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ITCM_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DTCM_BASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DTCM_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITCM_LOAD_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DTCM_LOAD_OFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VRAM_ENABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VRAM_HALF_OFF = 3'd6;

    typedef enum logic [3:0] {
        TGT_ITCM     = 4'd0,
        TGT_DTCM     = 4'd1,
        TGT_BIOS     = 4'd2,
        TGT_WRAM     = 4'd3,
        TGT_IO       = 4'd4,
        TGT_VRAM     = 4'd5,
        TGT_SHARED   = 4'd6,
        TGT_AXI      = 4'd7,
        TGT_FCRAM0   = 4'd8,
        TGT_FCRAM1   = 4'd9,
        TGT_UNMAPPED = 4'd10,
        TGT_FAULT    = 4'd11
    } target_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        access_size;
        logic [ADDR_W-1:0] address;
        logic              mpu_allows;
    } cbad_req_t;

    typedef struct packed {
        target_t             target;
        logic [OFFSET_W-1:0] offset;
    } cbad_rsp_t;

    // region match flags between the compare and select stages
    typedef struct packed {
        logic allow;
        logic itcm;
        logic dtcm;
        logic bios;
        logic wram;
        logic io;
        logic vram_win;
        logic vram_ok;
        logic shared;
        logic axi;
        logic fcram0;
        logic fcram1;
    } cbad_hit_t;

endpackage

// ===== rtl/core/cpu_bus_address_decoder.sv =====
// cpu bus address decoder: three-stage pipelined target and offset decode
//
//  channel   handshake             payload
//  access    start, busy           req (cbad_req_t)
//  result    done                  result (cbad_rsp_t)
//  config    cfg_write             cfg_index, cfg_data
//
// one transaction enters every cycle; busy is always low.
// done rises together with the result register once a transaction has passed
// the stages in order: align and capture, region compares (32-bit limit and
// mask compares), priority select.
// rst_n clears the stage valid bits and the configuration registers.
// nothing stalls: the receiver takes every result in its strobe cycle.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cpu_bus_address_decoder
    import cbad_pkg::*;
#(
    parameter int ITCM_PHYS_BYTES = ITCM_PHYS_BYTES_DEF,
    parameter int DTCM_PHYS_BYTES = DTCM_PHYS_BYTES_DEF,
    parameter int BIOS_BYTES      = BIOS_BYTES_DEF,
    parameter int WORKRAM_BYTES   = WORKRAM_BYTES_DEF,
    parameter int SHAREDRAM_BYTES = SHAREDRAM_BYTES_DEF,
    parameter int FCRAM_BYTES     = FCRAM_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cbad_req_t            req,
    output logic                 done,
    output cbad_rsp_t            result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam logic [OFFSET_W-1:0] ITCM_OFF_MASK   = OFFSET_W'(ITCM_PHYS_BYTES - 1);
    localparam logic [OFFSET_W-1:0] DTCM_OFF_MASK   = OFFSET_W'(DTCM_PHYS_BYTES - 1);
    localparam logic [OFFSET_W-1:0] BIOS_OFF_MASK   = OFFSET_W'(BIOS_BYTES - 1);
    localparam logic [OFFSET_W-1:0] WRAM_OFF_MASK   = OFFSET_W'(WORKRAM_BYTES - 1);
    localparam logic [OFFSET_W-1:0] SHARED_OFF_MASK = OFFSET_W'(SHAREDRAM_BYTES - 1);
    localparam logic [OFFSET_W-1:0] FCRAM_OFF_MASK  = OFFSET_W'(FCRAM_BYTES - 1);

    // configuration registers
    logic [ADDR_W-1:0] itcm_limit_reg;
    logic [ADDR_W-1:0] dtcm_base_reg;
    logic [ADDR_W-1:0] dtcm_mask_reg;
    logic              itcm_load_off_reg;
    logic              dtcm_load_off_reg;
    logic              vram_enable_reg;
    logic [3:0]        vram_half_off_reg;

    // stage 1: aligned access
    logic              s1_valid_reg;
    logic [1:0]        s1_mode_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_allow_reg;
    logic [ADDR_W-1:0] s1_addr_next;

    // stage 2: region flags
    logic              s2_valid_reg;
    cbad_hit_t         s2_hit_reg;
    cbad_hit_t         s2_hit_next;
    logic [ADDR_W-1:0] s2_addr_reg;

    // stage 3: result register
    logic              done_reg;
    cbad_rsp_t         result_reg;
    cbad_rsp_t         result_next;

    logic              accept;
    logic              s1_store;
    logic              s1_fetch;
    logic [1:0]        vram_half_sel;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itcm_limit_reg    <= '0;
            dtcm_base_reg     <= '0;
            dtcm_mask_reg     <= '0;
            itcm_load_off_reg <= 1'b0;
            dtcm_load_off_reg <= 1'b0;
            vram_enable_reg   <= 1'b0;
            vram_half_off_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ITCM_LIMIT:    itcm_limit_reg    <= cfg_data;
                CFG_DTCM_BASE:     dtcm_base_reg     <= cfg_data;
                CFG_DTCM_MASK:     dtcm_mask_reg     <= cfg_data;
                CFG_ITCM_LOAD_OFF: itcm_load_off_reg <= cfg_data[0];
                CFG_DTCM_LOAD_OFF: dtcm_load_off_reg <= cfg_data[0];
                CFG_VRAM_ENABLE:   vram_enable_reg   <= cfg_data[0];
                CFG_VRAM_HALF_OFF: vram_half_off_reg <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // fetches and word (or the unused size code) align to 4, halfwords to 2
    always_comb
    begin
        s1_addr_next = req.address;
        if (req.mode == MODE_FETCH || req.access_size[1])
        begin
            s1_addr_next[1:0] = 2'b00;
        end
        else if (req.access_size == SIZE_HALF)
        begin
            s1_addr_next[0] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= req.mode;
            s1_addr_reg  <= s1_addr_next;
            s1_allow_reg <= req.mpu_allows;
        end
    end

    // the unused mode code behaves as a load
    assign s1_store = (s1_mode_reg == MODE_STORE);
    assign s1_fetch = (s1_mode_reg == MODE_FETCH);
    // address bit 3 picks the high or low power half of a bank
    assign vram_half_sel = {s1_addr_reg >= VRAM_B_BASE, s1_addr_reg[3]};

    always_comb
    begin
        s2_hit_next.allow    = s1_allow_reg;
        s2_hit_next.itcm     = (s1_store || !itcm_load_off_reg)
                               && (s1_addr_reg < itcm_limit_reg);
        s2_hit_next.dtcm     = !s1_fetch && (s1_store || !dtcm_load_off_reg)
                               && ((s1_addr_reg & dtcm_mask_reg) == dtcm_base_reg);
        s2_hit_next.bios     = !s1_store && (s1_addr_reg >= BIOS_BASE);
        s2_hit_next.wram     = (s1_addr_reg & REGION_MASK_128M) == WORKRAM_BASE;
        s2_hit_next.io       = (s1_addr_reg >= IO_BASE) && (s1_addr_reg < IO_END);
        s2_hit_next.vram_win = (s1_addr_reg >= VRAM_BASE) && (s1_addr_reg < VRAM_END);
        s2_hit_next.vram_ok  = vram_enable_reg && !vram_half_off_reg[vram_half_sel];
        s2_hit_next.shared   = (s1_addr_reg & REGION_MASK_512K) == SHAREDRAM_BASE;
        s2_hit_next.axi      = (s1_addr_reg & REGION_MASK_512K) == AXIRAM_BASE;
        s2_hit_next.fcram0   = (s1_addr_reg & REGION_MASK_128M) == FCRAM0_BASE;
        s2_hit_next.fcram1   = (s1_addr_reg & REGION_MASK_128M) == FCRAM1_BASE;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_hit_reg  <= s2_hit_next;
            s2_addr_reg <= s1_addr_reg;
        end
    end

    // priority select and offset
    always_comb
    begin
        result_next.target = TGT_UNMAPPED;
        result_next.offset = '0;
        if (!s2_hit_reg.allow)
        begin
            result_next.target = TGT_FAULT;
        end
        else if (s2_hit_reg.itcm)
        begin
            result_next.target = TGT_ITCM;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & ITCM_OFF_MASK;
        end
        else if (s2_hit_reg.dtcm)
        begin
            result_next.target = TGT_DTCM;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & DTCM_OFF_MASK;
        end
        else if (s2_hit_reg.bios)
        begin
            result_next.target = TGT_BIOS;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & BIOS_OFF_MASK;
        end
        else if (s2_hit_reg.wram)
        begin
            result_next.target = TGT_WRAM;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & WRAM_OFF_MASK;
        end
        else if (s2_hit_reg.io)
        begin
            result_next.target = TGT_IO;
            result_next.offset = OFFSET_W'(s2_addr_reg - IO_BASE);
        end
        else if (s2_hit_reg.vram_win)
        begin
            // disabled or powered-off vram reads as unmapped
            if (s2_hit_reg.vram_ok)
            begin
                result_next.target = TGT_VRAM;
                result_next.offset = OFFSET_W'(s2_addr_reg - VRAM_BASE);
            end
        end
        else if (s2_hit_reg.shared)
        begin
            result_next.target = TGT_SHARED;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & SHARED_OFF_MASK;
        end
        else if (s2_hit_reg.axi)
        begin
            result_next.target = TGT_AXI;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & AXIRAM_OFF_MASK;
        end
        else if (s2_hit_reg.fcram0)
        begin
            result_next.target = TGT_FCRAM0;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & FCRAM_OFF_MASK;
        end
        else if (s2_hit_reg.fcram1)
        begin
            result_next.target = TGT_FCRAM1;
            result_next.offset = s2_addr_reg[OFFSET_W-1:0] & FCRAM_OFF_MASK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every accepted transaction comes out with a result strobe
    `ASSERT_CLK(a_latency, clk, rst_n, accept |-> ##3 done, "result strobe missing")
    `ASSERT_CLK(a_no_orphan, clk, rst_n, done |-> $past(s1_valid_reg, 2),
        "result strobe without transaction")
    `ASSERT_NEVER(a_zero_offset, clk, rst_n,
        done && (result.target == TGT_FAULT || result.target == TGT_UNMAPPED)
        && (result.offset != '0), "fault or unmapped with nonzero offset")
    `ASSERT_NEVER(a_itcm_range, clk, rst_n,
        done && (result.target == TGT_ITCM) && ((result.offset & ~ITCM_OFF_MASK) != '0),
        "itcm offset beyond physical size")

endmodule
